// File: design/rdat_pkg.sv
// rdat_pkg: shared types and constants for the reliable datagram ack tracker
// no dependencies
`default_nettype none
package rdat_pkg;
  localparam logic [1:0] MODE_RX = 2'd0;
  localparam logic [1:0] MODE_TX = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_NOP = 2'd3;

  localparam logic [2:0] KIND_VERDICT = 3'd0;
  localparam logic [2:0] KIND_DATA = 3'd1;
  localparam logic [2:0] KIND_RESEND = 3'd2;
  localparam logic [2:0] KIND_KEEPALIVE = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [1:0] REG_RESEND = 2'd0;
  localparam logic [1:0] REG_KEEPALIVE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_FROM_START = 2'd3;

  localparam int AckSpan = 33;

  // most resends issued by one tick
  localparam logic [5:0] RESEND_CAP = 6'd32;

  // one-hot sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_ACK   = 8'b0000_0010,  // sweep table releasing acked ids
    ST_FIND  = 8'b0000_0100,  // search for same id / free slot
    ST_REC   = 8'b0000_1000,  // write recorded entry
    ST_SCAN  = 8'b0001_0000,  // tick resend scan
    ST_KEEP  = 8'b0010_0000,
    ST_STAT  = 8'b0100_0000,
    ST_RXOUT = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic       vld;
    logic [2:0] kind;
    logic [30:0] seq;
    logic       deliver;
    logic       closed;
    logic       last;
  } res_t;
endpackage
`default_nettype wire

// File: design/reliable_datagram_ack_tracker.sv
// reliable_datagram_ack_tracker: top level sequencer around the pending table (rdat_pkg, rdat_pend_mem)
// data header in the cycle after start; verdict from ST_RXOUT, after an ST_ACK sweep for a valid ack
// tick status from ST_STAT after ST_SCAN and ST_KEEP; in the cycle after start if the link is closed
// busy: reliable send, ack sweep and tick each read the whole table, one read a cycle
// reset clears the valid bits and control state at once; no clearing pass
// results are strobed for one cycle each, the receiver cannot stall
`default_nettype none
module reliable_datagram_ack_tracker #(
  parameter int PENDING_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [30:0] rx_seq_i,
  input  wire logic signed [31:0] rx_ack_i,
  input  wire logic [31:0] rx_ack_bits_i,
  input  wire logic        rx_has_payload_i,
  input  wire logic        tx_reliable_i,
  output      logic        res_valid_o,
  output      logic [2:0]  kind_o,
  output      logic [30:0] seq_id_o,
  output      logic signed [31:0] ack_id_o,
  output      logic [31:0] ack_bits_o,
  output      logic        deliver_o,
  output      logic        closed_o,
  output      logic        last_o
);
  import rdat_pkg::*;
  localparam int Aw = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int Cw = $clog2(PENDING_DEPTH + 2);

  // configuration registers
  logic [15:0] resend_q, keep_q, tmo_q;
  logic        from_start_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resend_q <= 16'd1000; keep_q <= 16'd250; tmo_q <= 16'd5000; from_start_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RESEND:     resend_q <= cfg_data_i;
        REG_KEEPALIVE:  keep_q <= cfg_data_i;
        REG_TIMEOUT:    tmo_q <= cfg_data_i;
        REG_FROM_START: from_start_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [31:0] high_q, high_d;
  logic [32:0] win_q, win_d;
  logic [30:0] next_q, next_d;
  logic [PENDING_DEPTH-1:0] pv_q, pv_d;
  logic [31:0] now_q, now_d, ltx_q, ltx_d, lrx_q, lrx_d, txb_q, txb_d;
  logic rxs_q, rxs_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic [31:0] ack_q, ack_d, bits_q, bits_d;
  logic [30:0] sid_q, sid_d;
  logic dlv_q, dlv_d;
  logic same_q, same_d, free_q, free_d;
  logic [Aw-1:0] slot_q, slot_d;
  logic [5:0] rsn_q, rsn_d;
  res_t res_q, res_d;

  logic we;
  logic [Aw-1:0] waddr, raddr;
  logic [62:0] wdata, rdata;
  rdat_pend_mem #(.Depth(PENDING_DEPTH), .Aw(Aw)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // entry index whose read data arrives this cycle
  logic [Aw-1:0] cur;
  logic [30:0] rseq;
  logic [31:0] rtime, age;
  logic [32:0] diff;
  logic acked;
  assign cur = Aw'(cnt_q - Cw'(1));
  assign rseq = rdata[62:32];
  assign rtime = rdata[31:0];
  assign age = now_q - rtime;
  // ack test: id == ack, or ack - id in 1..32 with bit set
  assign diff = {2'b0, ack_q[30:0]} - {2'b0, rseq};
  always_comb begin
    acked = 1'b0;
    if (diff == 33'd0) acked = 1'b1;
    else if (!diff[32] && diff <= 33'd32) acked = bits_q[5'(diff[5:0] - 6'd1)];
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    logic [32:0] d;
    logic [32:0] k;
    state_d = state_q; high_d = high_q; win_d = win_q; next_d = next_q;
    pv_d = pv_q; now_d = now_q; ltx_d = ltx_q; lrx_d = lrx_q; txb_d = txb_q;
    rxs_d = rxs_q; cnt_d = cnt_q; ack_d = ack_q; bits_d = bits_q; sid_d = sid_q;
    dlv_d = dlv_q; same_d = same_q; free_d = free_q; slot_d = slot_q;
    rsn_d = rsn_q;
    res_d = '0; we = 1'b0; waddr = cur; wdata = {rseq, now_q};
    raddr = cnt_q[Aw-1:0];
    d = '0; k = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        raddr = '0;
        if (start) begin
          cnt_d = Cw'(1);
          case (mode_i)
            MODE_RX: begin
              lrx_d = now_q; rxs_d = 1'b1;
              d = {2'b0, rx_seq_i} - {high_q[31], high_q};
              if (!d[32] && d != 33'd0) begin
                win_d = (d >= 33'd33) ? '0 : win_q << d[5:0];
                high_d = {1'b0, rx_seq_i};
              end
              dlv_d = 1'b0;
              if (rx_has_payload_i) begin
                k = {high_d[31], high_d} - {2'b0, rx_seq_i};
                if (!k[32] && k <= 33'd32 && !win_d[k[5:0]]) begin
                  win_d[k[5:0]] = 1'b1; dlv_d = 1'b1;
                end
              end
              ack_d = rx_ack_i; bits_d = rx_ack_bits_i;
              state_d = rx_ack_i[31] ? ST_RXOUT : ST_ACK;
            end
            MODE_TX: begin
              next_d = next_q + 31'd1; sid_d = next_q + 31'd1;
              ltx_d = now_q;
              same_d = 1'b0; free_d = 1'b0;
              res_d = '{vld: 1'b1, kind: KIND_DATA, seq: next_q + 31'd1,
                        deliver: 1'b0, closed: 1'b0, last: 1'b1};
              state_d = tx_reliable_i ? ST_FIND : ST_IDLE;
            end
            MODE_TICK: begin
              now_d = now_q + 32'd1; txb_d = ltx_q; rsn_d = '0;
              if ((rxs_q || from_start_q) && (now_q + 32'd1 - lrx_q) >= {16'd0, tmo_q}) begin
                res_d = '{vld: 1'b1, kind: KIND_STATUS, seq: '0,
                          deliver: 1'b0, closed: 1'b1, last: 1'b1};
                state_d = ST_IDLE;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ACK: begin
        if (pv_q[cur] && acked) pv_d[cur] = 1'b0;
        cnt_d = cnt_q + Cw'(1);
        if (cnt_q == Cw'(PENDING_DEPTH)) state_d = ST_RXOUT;
      end
      ST_RXOUT: begin
        res_d = '{vld: 1'b1, kind: KIND_VERDICT, seq: '0,
                  deliver: dlv_q, closed: 1'b0, last: 1'b1};
        state_d = ST_IDLE;
      end
      ST_FIND: begin
        // first valid same-id slot wins, else first free slot
        if (pv_q[cur] && rseq == sid_q && !same_q) begin
          same_d = 1'b1; slot_d = cur;
        end else if (!pv_q[cur] && !free_q && !same_q) begin
          free_d = 1'b1; slot_d = cur;
        end
        cnt_d = cnt_q + Cw'(1);
        if (cnt_q == Cw'(PENDING_DEPTH)) state_d = ST_REC;
      end
      ST_REC: begin
        if (same_q || free_q) begin
          we = 1'b1; waddr = slot_q; wdata = {sid_q, now_q}; pv_d[slot_q] = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        // stale entries are resent in table order, up to the cap per tick
        if (pv_q[cur] && age >= {16'd0, resend_q} && rsn_q != RESEND_CAP) begin
          res_d = '{vld: 1'b1, kind: KIND_RESEND, seq: rseq,
                    deliver: 1'b0, closed: 1'b0, last: 1'b0};
          we = 1'b1; ltx_d = now_q; rsn_d = rsn_q + 6'd1;
        end
        cnt_d = cnt_q + Cw'(1);
        if (cnt_q == Cw'(PENDING_DEPTH)) state_d = ST_KEEP;
      end
      ST_KEEP: begin
        if ((now_q - txb_q) >= {16'd0, keep_q}) begin
          next_d = next_q + 31'd1; ltx_d = now_q;
          res_d = '{vld: 1'b1, kind: KIND_KEEPALIVE, seq: next_q + 31'd1,
                    deliver: 1'b0, closed: 1'b0, last: 1'b0};
        end
        state_d = ST_STAT;
      end
      ST_STAT: begin
        res_d = '{vld: 1'b1, kind: KIND_STATUS, seq: '0,
                  deliver: 1'b0, closed: 1'b0, last: 1'b1};
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; high_q <= '1; win_q <= '0; next_q <= '0; pv_q <= '0;
      now_q <= '0; ltx_q <= '0; lrx_q <= '0; rxs_q <= 1'b0; cnt_q <= '0;
      res_q <= '0;
    end else begin
      state_q <= state_d; high_q <= high_d; win_q <= win_d; next_q <= next_d;
      pv_q <= pv_d; now_q <= now_d; ltx_q <= ltx_d; lrx_q <= lrx_d; rxs_q <= rxs_d;
      cnt_q <= cnt_d; res_q <= res_d;
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    txb_q <= txb_d; ack_q <= ack_d; bits_q <= bits_d; sid_q <= sid_d;
    dlv_q <= dlv_d; same_q <= same_d; free_q <= free_d;
    slot_q <= slot_d; rsn_q <= rsn_d;
  end

  // result transfer
  assign res_valid_o = res_q.vld;
  assign kind_o = res_q.kind;
  assign seq_id_o = res_q.seq;
  assign ack_id_o = high_q;
  assign ack_bits_o = win_q[32:1];
  assign deliver_o = res_q.deliver;
  assign closed_o = res_q.closed;
  assign last_o = res_q.last;
endmodule
`default_nettype wire

// File: design/rdat_pend_mem.sv
// rdat_pend_mem: pending table storage, sequence id and send time per slot
// no dependencies; one write port, one registered read port
`default_nettype none
module rdat_pend_mem #(
  parameter int Depth = 32,
  parameter int Aw = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [62:0]   wdata_i,
  input  wire logic [Aw-1:0] raddr_i,
  output      logic [62:0]   rdata_o
);
  logic [62:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/rdat_checker.sv
// rdat_checker: port-level assertions for the ack tracker
// binds to reliable_datagram_ack_tracker; uses rdat_pkg
`default_nettype none
module rdat_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       res_valid_o,
  input wire logic [2:0] kind_o,
  input wire logic       deliver_o,
  input wire logic       closed_o,
  input wire logic       last_o
);
  import rdat_pkg::*;
  // closed only on a final status result
  a_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && closed_o |-> kind_o == KIND_STATUS && last_o) else $error("closed");
  // deliver only on a receive verdict
  a_dlv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && deliver_o |-> kind_o == KIND_VERDICT) else $error("deliver");
  // verdicts and data headers are always last
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == KIND_VERDICT || kind_o == KIND_DATA) |-> last_o)
    else $error("last");
  // resends never end an item
  a_rs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && kind_o == KIND_RESEND |-> !last_o && busy) else $error("resend");
endmodule
bind reliable_datagram_ack_tracker rdat_checker u_chk (.*);
`default_nettype wire
